### sv/heightfield_grid_triangulator_unit_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef HEIGHTFIELD_GRID_TRIANGULATOR_UNIT_MACROS_SVH
`define HEIGHTFIELD_GRID_TRIANGULATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HGT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HGT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/hgt_pkg.sv
`default_nettype none
package hgt_pkg;

    localparam int unsigned MAX_COLUMNS_DEF          = 4096;
    localparam int unsigned NORMAL_FRACTION_BITS_DEF = 14;
    localparam int unsigned QUEUE_DEPTH              = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int COORD_W     = 48;
    localparam int Z_W         = 32;
    localparam int DIFF_W      = 33;
    localparam int SPACING_W   = 32;
    localparam int NORMAL_W    = 16;
    localparam int COLS_CFG_W  = 13;
    localparam int NODATA_W    = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_ORIGIN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COL_ORIGIN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPACING    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NODATA     = 3'd4;

    localparam logic [COLS_CFG_W-1:0] COLUMNS_RESET = 13'd2;
    localparam logic [SPACING_W-1:0]  SPACING_RESET = 32'd65536;
    localparam logic [NODATA_W-1:0]   NODATA_RESET  = 16'hD8F1;

    // One triangle handed from the front to the back.
    typedef struct packed {
        logic [COORD_W-1:0]       rlo;
        logic [COORD_W-1:0]       rhi;
        logic [COORD_W-1:0]       clo;
        logic [COORD_W-1:0]       chi;
        logic                     kind;
        logic [Z_W-1:0]           z1;
        logic [Z_W-1:0]           z2;
        logic [Z_W-1:0]           z3;
        logic signed [DIFF_W-1:0] v0;
        logic signed [DIFF_W-1:0] v1;
        logic [SPACING_W-1:0]     s;
        logic                     last;
    } job_t;

    // Integer part truncated toward zero, compared with the marker.
    function automatic logic is_nodata(input logic [Z_W-1:0] z,
                                       input logic [NODATA_W-1:0] marker);
        logic [16:0] ip;
        ip = {z[31], z[31:16]} + ((z[31] && (|z[15:0])) ? 17'd1 : 17'd0);
        return ip == {marker[15], marker};
    endfunction

endpackage
`default_nettype wire

### sv/hgt_if.sv
`default_nettype none
interface hgt_sample_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] elevation;

    modport source (output valid, output elevation, input ready);
    modport sink (input valid, input elevation, output ready);
endinterface

interface hgt_tri_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] row_coord_low;
    logic signed [47:0] row_coord_high;
    logic signed [47:0] col_coord_low;
    logic signed [47:0] col_coord_high;
    logic               triangle_kind;
    logic signed [31:0] z_first;
    logic signed [31:0] z_second;
    logic signed [31:0] z_third;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               last_of_run;

    modport source (output valid, output row_coord_low, output row_coord_high,
                    output col_coord_low, output col_coord_high, output triangle_kind,
                    output z_first, output z_second, output z_third, output normal_x,
                    output normal_y, output normal_z, output last_of_run, input ready);
    modport sink (input valid, input row_coord_low, input row_coord_high,
                  input col_coord_low, input col_coord_high, input triangle_kind,
                  input z_first, input z_second, input z_third, input normal_x,
                  input normal_y, input normal_z, input last_of_run, output ready);
endinterface
`default_nettype wire

### sv/hgt_queue.sv
`default_nettype none
module hgt_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  hgt_pkg::job_t din,
    output logic         full,
    input  logic         pop,
    output hgt_pkg::job_t dout,
    output logic         empty
);
    import hgt_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    job_t          slot_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign full  = count_reg == (AW+1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign dout  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

### sv/hgt_front.sv
`default_nettype none
`include "heightfield_grid_triangulator_unit_macros.svh"
module hgt_front #(
    parameter int unsigned MAX_COLUMNS = hgt_pkg::MAX_COLUMNS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    hgt_sample_if.sink                        sample,
    input  logic                              cfg_we,
    input  logic [hgt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hgt_pkg::CFG_DATA_W-1:0]    cfg_data,
    output hgt_pkg::job_t                     job,
    output logic                              job_push,
    input  logic                              job_full
);
    import hgt_pkg::*;

    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int NW = CW + 1;

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_READ  = 3'd1;
    localparam logic [2:0] F_EVAL  = 3'd2;
    localparam logic [2:0] F_PUSH1 = 3'd3;
    localparam logic [2:0] F_FIN   = 3'd4;

    logic [2:0]            state_reg;
    logic [COLS_CFG_W-1:0] cols_reg;
    logic [COORD_W-1:0]    row_org_reg;
    logic [COORD_W-1:0]    col_org_reg;
    logic [SPACING_W-1:0]  spacing_reg;
    logic [NODATA_W-1:0]   nodata_reg;
    logic [CW-1:0]         col_reg;
    logic                  first_reg;
    logic [COORD_W-1:0]    row_acc_reg;
    logic [COORD_W-1:0]    col_acc_reg;
    logic [Z_W-1:0]        left_reg;
    logic [Z_W-1:0]        za_reg;
    logic [Z_W-1:0]        zd_reg;
    logic [Z_W-1:0]        rd_data_reg;

    logic [Z_W-1:0] line_mem [MAX_COLUMNS];

    logic [NW-1:0]      cols_eff;
    logic [CW-1:0]      col_cur;
    logic               is_last;
    logic               cell_ok;
    logic               t0;
    logic               t1;
    logic [COORD_W-1:0] rhi;
    logic [COORD_W-1:0] chi;
    logic               mem_we;
    logic [CW-1:0]      mem_waddr;
    logic [Z_W-1:0]     mem_wdata;
    logic               cfg_hit;

    always_comb
    begin
        if (cols_reg < COLUMNS_RESET)
        begin
            cols_eff = NW'(2);
        end
        else if (32'(cols_reg) > 32'(MAX_COLUMNS))
        begin
            cols_eff = NW'(MAX_COLUMNS);
        end
        else
        begin
            cols_eff = NW'(cols_reg);
        end
        if ({1'b0, col_reg} >= cols_eff)
        begin
            col_cur = CW'(cols_eff - 1'b1);
        end
        else
        begin
            col_cur = col_reg;
        end
    end

    assign is_last = ({1'b0, col_cur} + 1'b1) >= cols_eff;
    assign rhi     = row_acc_reg + COORD_W'(spacing_reg);
    assign chi     = col_acc_reg + COORD_W'(spacing_reg);

    // a is held from the previous sample's read of b, so one read per sample is enough.
    assign cell_ok = (col_cur != '0) && !first_reg && !is_nodata(za_reg, nodata_reg)
                     && !is_nodata(zd_reg, nodata_reg);
    assign t0 = cell_ok && !is_nodata(left_reg, nodata_reg);
    assign t1 = cell_ok && !is_nodata(rd_data_reg, nodata_reg);

    always_comb
    begin
        job.rlo  = row_acc_reg;
        job.rhi  = rhi;
        job.clo  = col_acc_reg;
        job.chi  = chi;
        job.s    = spacing_reg;
        job.z1   = za_reg;
        if (state_reg == F_PUSH1)
        begin
            job.kind = 1'b1;
            job.z2   = zd_reg;
            job.z3   = rd_data_reg;
            job.v0   = DIFF_W'($signed(rd_data_reg)) - DIFF_W'($signed(zd_reg));
            job.v1   = DIFF_W'($signed(za_reg)) - DIFF_W'($signed(rd_data_reg));
            job.last = 1'b1;
        end
        else
        begin
            job.kind = 1'b0;
            job.z2   = left_reg;
            job.z3   = zd_reg;
            job.v0   = DIFF_W'($signed(za_reg)) - DIFF_W'($signed(left_reg));
            job.v1   = DIFF_W'($signed(left_reg)) - DIFF_W'($signed(zd_reg));
            job.last = !t1;
        end
    end

    assign job_push = !job_full && (((state_reg == F_EVAL) && t0) || (state_reg == F_PUSH1));
    assign sample.ready = state_reg == F_IDLE;
    assign cfg_hit = cfg_we && (cfg_index <= REG_NODATA);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = col_cur;
        mem_wdata = zd_reg;
        if ((state_reg == F_READ) && (col_cur != '0))
        begin
            mem_we    = 1'b1;
            mem_waddr = col_cur - 1'b1;
            mem_wdata = left_reg;
        end
        else if ((state_reg == F_FIN) && is_last)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == F_READ)
        begin
            rd_data_reg <= line_mem[col_cur];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            cols_reg    <= COLUMNS_RESET;
            row_org_reg <= '0;
            col_org_reg <= '0;
            spacing_reg <= SPACING_RESET;
            nodata_reg  <= NODATA_RESET;
            col_reg     <= '0;
            first_reg   <= 1'b1;
            row_acc_reg <= '0;
            col_acc_reg <= '0;
            left_reg    <= '0;
            za_reg      <= '0;
            zd_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (sample.valid)
                    begin
                        zd_reg    <= sample.elevation;
                        state_reg <= F_READ;
                    end
                end
                F_READ:
                begin
                    state_reg <= F_EVAL;
                end
                F_EVAL:
                begin
                    if (!t0 || !job_full)
                    begin
                        state_reg <= t1 ? F_PUSH1 : F_FIN;
                    end
                end
                F_PUSH1:
                begin
                    if (!job_full)
                    begin
                        state_reg <= F_FIN;
                    end
                end
                F_FIN:
                begin
                    left_reg <= zd_reg;
                    za_reg   <= rd_data_reg;
                    if (is_last)
                    begin
                        col_reg     <= '0;
                        col_acc_reg <= col_org_reg;
                        if (first_reg)
                        begin
                            first_reg <= 1'b0;
                        end
                        else
                        begin
                            row_acc_reg <= rhi;
                        end
                    end
                    else
                    begin
                        col_reg <= col_cur + 1'b1;
                        if (col_cur != '0)
                        begin
                            col_acc_reg <= chi;
                        end
                    end
                    state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase

            // Any write to a defined register (index 0 to 4) restarts the raster from a fresh first row.
            if (cfg_hit)
            begin
                unique case (cfg_index)
                    REG_COLUMNS:    cols_reg    <= cfg_data[COLS_CFG_W-1:0];
                    REG_ROW_ORIGIN: row_org_reg <= cfg_data[COORD_W-1:0];
                    REG_COL_ORIGIN: col_org_reg <= cfg_data[COORD_W-1:0];
                    REG_SPACING:    spacing_reg <= cfg_data[SPACING_W-1:0];
                    default:        nodata_reg  <= cfg_data[NODATA_W-1:0];
                endcase
                col_reg   <= '0;
                first_reg <= 1'b1;
                row_acc_reg <= (cfg_index == REG_ROW_ORIGIN) ? cfg_data[COORD_W-1:0]
                                                             : row_org_reg;
                col_acc_reg <= (cfg_index == REG_COL_ORIGIN) ? cfg_data[COORD_W-1:0]
                                                             : col_org_reg;
            end
        end
    end

    `HGT_ASSERT_NOW(a_push_state, job_push, (state_reg == F_EVAL) || (state_reg == F_PUSH1), "push outside evaluation")
    `HGT_ASSERT_NOW(a_push_cell, job_push, !first_reg && (col_cur != '0), "triangle from a cell without an earlier row or column")
    `HGT_ASSERT_NEXT(a_fin_idle, state_reg == F_FIN, state_reg == F_IDLE, "sample not retired after finish")
endmodule
`default_nettype wire

### sv/hgt_back.sv
`default_nettype none
`include "heightfield_grid_triangulator_unit_macros.svh"
module hgt_back #(
    parameter int unsigned NORMAL_FRACTION_BITS = hgt_pkg::NORMAL_FRACTION_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  hgt_pkg::job_t job,
    input  logic          job_empty,
    output logic          job_pop,
    hgt_tri_if.source     triangle
);
    import hgt_pkg::*;

    localparam int F    = NORMAL_FRACTION_BITS;
    localparam int QW   = F + 2;
    localparam int CMPW = F + 35;
    localparam int QCW  = $clog2(QW);
    localparam int SW   = 62;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_MAG   = 3'd1;
    localparam logic [2:0] B_SQ    = 3'd2;
    localparam logic [2:0] B_SQRT  = 3'd3;
    localparam logic [2:0] B_DLOAD = 3'd4;
    localparam logic [2:0] B_DIV   = 3'd5;
    localparam logic [2:0] B_OUT   = 3'd6;

    logic [2:0]          state_reg;
    job_t                job_reg;
    logic [29:0]         w_reg [3];
    logic [2:0]          neg_reg;
    logic [1:0]          idx_reg;
    logic [SW-1:0]       sum_reg;
    logic [SW-1:0]       rad_reg;
    logic [SW-1:0]       root_reg;
    logic [SW-1:0]       bit_reg;
    logic [31:0]         len_reg;
    logic [CMPW-1:0]     rem_reg;
    logic [QW-1:0]       q_reg;
    logic [QCW-1:0]      qi_reg;
    logic [NORMAL_W-1:0] nrm_reg [3];
    logic                out_valid_reg;
    job_t                out_job_reg;
    logic [NORMAL_W-1:0] out_nrm_reg [3];

    logic [DIFF_W-1:0] mag [3];
    logic [DIFF_W-1:0] mag_max;
    logic [1:0]        k;
    logic [59:0]       prod;
    logic [SW-1:0]     trial;
    logic [CMPW-1:0]   den_sh;
    logic [QW-1:0]     q_full;
    logic [31:0]       q_signed;
    logic              load_out;

    always_comb
    begin
        mag[0] = job_reg.v0[DIFF_W-1] ? DIFF_W'(-job_reg.v0) : DIFF_W'(job_reg.v0);
        mag[1] = job_reg.v1[DIFF_W-1] ? DIFF_W'(-job_reg.v1) : DIFF_W'(job_reg.v1);
        mag[2] = DIFF_W'(job_reg.s);
        mag_max = (mag[0] > mag[1]) ? mag[0] : mag[1];
        if (mag[2] > mag_max)
        begin
            mag_max = mag[2];
        end
        // Smallest right shift that brings the largest magnitude under 2^30.
        priority if (mag_max[32])
        begin
            k = 2'd3;
        end
        else if (mag_max[31])
        begin
            k = 2'd2;
        end
        else if (mag_max[30])
        begin
            k = 2'd1;
        end
        else
        begin
            k = 2'd0;
        end
    end

    assign prod   = 60'(w_reg[idx_reg]) * 60'(w_reg[idx_reg]);
    assign trial  = root_reg + bit_reg;
    assign den_sh = CMPW'({len_reg, 1'b0}) << qi_reg;

    // Final quotient bit is folded in here so the stored normal sees the whole quotient.
    assign q_full = {q_reg[QW-1:1], rem_reg >= den_sh};

    always_comb
    begin
        q_signed = (len_reg == '0) ? 32'd0 : 32'(q_full);
        if (neg_reg[idx_reg])
        begin
            q_signed = -q_signed;
        end
    end

    assign job_pop  = (state_reg == B_IDLE) && !job_empty;
    assign load_out = (state_reg == B_OUT) && (!out_valid_reg || triangle.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            qi_reg        <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (triangle.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!job_empty)
                    begin
                        state_reg <= B_MAG;
                    end
                end
                B_MAG:
                begin
                    idx_reg   <= '0;
                    state_reg <= B_SQ;
                end
                B_SQ:
                begin
                    if (idx_reg == 2'd2)
                    begin
                        state_reg <= B_SQRT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                B_SQRT:
                begin
                    if (bit_reg[0])
                    begin
                        idx_reg   <= '0;
                        state_reg <= B_DLOAD;
                    end
                end
                B_DLOAD:
                begin
                    qi_reg    <= QCW'(QW - 1);
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    if (qi_reg == '0)
                    begin
                        if (idx_reg == 2'd2)
                        begin
                            state_reg <= B_OUT;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= B_DLOAD;
                        end
                    end
                    else
                    begin
                        qi_reg <= qi_reg - 1'b1;
                    end
                end
                B_OUT:
                begin
                    if (load_out)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                job_reg <= job;
            end
            B_MAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    w_reg[i] <= 30'(mag[i] >> k);
                end
                neg_reg <= {1'b0, job_reg.v1[DIFF_W-1], job_reg.v0[DIFF_W-1]};
                sum_reg <= '0;
            end
            B_SQ:
            begin
                sum_reg  <= sum_reg + SW'(prod);
                rad_reg  <= sum_reg + SW'(prod);
                root_reg <= '0;
                bit_reg  <= SW'(1) << 60;
            end
            B_SQRT:
            begin
                if (rad_reg >= trial)
                begin
                    rad_reg  <= rad_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                    len_reg  <= 32'((root_reg >> 1) + bit_reg);
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                    len_reg  <= 32'(root_reg >> 1);
                end
                bit_reg <= bit_reg >> 2;
            end
            B_DLOAD:
            begin
                rem_reg <= (CMPW'(w_reg[idx_reg]) << (F + 1)) + CMPW'(len_reg);
                q_reg   <= '0;
            end
            B_DIV:
            begin
                if (rem_reg >= den_sh)
                begin
                    rem_reg        <= rem_reg - den_sh;
                    q_reg[qi_reg]  <= 1'b1;
                end
                if (qi_reg == '0)
                begin
                    nrm_reg[idx_reg] <= q_signed[NORMAL_W-1:0];
                end
            end
            default:
            begin
                if (load_out)
                begin
                    out_job_reg <= job_reg;
                    for (int i = 0; i < 3; i++)
                    begin
                        out_nrm_reg[i] <= nrm_reg[i];
                    end
                end
            end
        endcase
    end

    assign triangle.valid          = out_valid_reg;
    assign triangle.row_coord_low  = out_job_reg.rlo;
    assign triangle.row_coord_high = out_job_reg.rhi;
    assign triangle.col_coord_low  = out_job_reg.clo;
    assign triangle.col_coord_high = out_job_reg.chi;
    assign triangle.triangle_kind  = out_job_reg.kind;
    assign triangle.z_first        = out_job_reg.z1;
    assign triangle.z_second       = out_job_reg.z2;
    assign triangle.z_third        = out_job_reg.z3;
    assign triangle.normal_x       = out_nrm_reg[0];
    assign triangle.normal_y       = out_nrm_reg[1];
    assign triangle.normal_z       = out_nrm_reg[2];
    assign triangle.last_of_run    = out_job_reg.last;

    `HGT_ASSERT_NOW(a_sqrt_onehot, state_reg == B_SQRT, $onehot(bit_reg), "square root step bit lost")
    `HGT_ASSERT_NOW(a_pop_idle, job_pop, state_reg == B_IDLE, "queue read while busy")
    `HGT_ASSERT_NEXT(a_sqrt_done, (state_reg == B_SQRT) && bit_reg[0], state_reg == B_DLOAD, "square root did not hand over to divide")
endmodule
`default_nettype wire

### sv/heightfield_grid_triangulator_unit.sv
// Channel   | Dir | Payload                                       | Transfer when
// sample    | in  | elevation (Q16.16)                            | valid && ready
// triangle  | out | coords, kind, three z, normal, last_of_run    | valid && ready
// cfg       | in  | cfg_index, cfg_data                           | cfg_we high
//
// Front: each sample passes accept, line store read, evaluate and retire, with a second push
// step when both triangles are made, one queue transfer each; a full queue holds it in its push steps.
// Back, one triangle at a time: queue read, scaling, three squares, a 31-step square root,
// three divisions of NORMAL_FRACTION_BITS + 2 quotient bits each after a load step, output.
// Reset clears all control state; the line store needs no clearing pass.
// Output stalls fill the result register, then the queue, then stall the sample side.
`default_nettype none
module heightfield_grid_triangulator_unit #(
    parameter int unsigned MAX_COLUMNS          = hgt_pkg::MAX_COLUMNS_DEF,
    parameter int unsigned NORMAL_FRACTION_BITS = hgt_pkg::NORMAL_FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    hgt_sample_if.sink                      sample,
    hgt_tri_if.source                       triangle,
    input  logic                            cfg_we,
    input  logic [hgt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hgt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hgt_pkg::*;

    job_t front_job;
    job_t queue_job;
    logic push;
    logic full;
    logic pop;
    logic empty;

    hgt_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job       (front_job),
        .job_push  (push),
        .job_full  (full)
    );

    hgt_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_job),
        .full  (full),
        .pop   (pop),
        .dout  (queue_job),
        .empty (empty)
    );

    hgt_back #(
        .NORMAL_FRACTION_BITS (NORMAL_FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (queue_job),
        .job_empty (empty),
        .job_pop   (pop),
        .triangle  (triangle)
    );
endmodule
`default_nettype wire

### bench/tb_heightfield_grid_triangulator_unit.sv
`default_nettype none
module tb_heightfield_grid_triangulator_unit;
    import hgt_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int FRAC_BITS   = 14;
    localparam int DRAIN_WAIT  = 400;
    localparam int LONG_HOLD   = 600;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [47:0] rlo;
        logic [47:0] rhi;
        logic [47:0] clo;
        logic [47:0] chi;
        logic        kind;
        logic [31:0] z1;
        logic [31:0] z2;
        logic [31:0] z3;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        last;
    } triangle_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    hgt_sample_if smp ();
    hgt_tri_if    trif ();

    heightfield_grid_triangulator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp),
        .triangle  (trif),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers and the grid walk.
    logic [12:0] grid_cols;
    logic [47:0] row_origin;
    logic [47:0] col_origin;
    logic [31:0] spacing;
    logic [15:0] marker;
    logic [31:0] line_mem [0:4095];
    logic [31:0] left_z;
    int unsigned col_pos;
    bit          in_first_row;
    logic [47:0] row_acc;
    logic [47:0] col_acc;

    logic [31:0] sample_queue [$];
    triangle_t   triangle_queue [$];
    int          fail_count;
    longint      cycle_count;
    int          gap_left;
    int          nogap_left;
    int          hold_left;
    bit          long_hold_go;
    bit          long_hold_done;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void add_sample(input logic [31:0] z);
        sample_queue.insert(sample_queue.size(), z);
    endfunction

    function automatic bit nodata(input logic [31:0] z);
        longint e;
        longint ip;
        e  = longint'($signed(z));
        ip = (e >= 0) ? (e >>> 16) : -((-e) >>> 16);
        return ip == longint'($signed(marker));
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = 0;
        b = 64'd1 << 62;
        x = v;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic triangle_t build_triangle(input bit kind, input longint v0,
                                                 input longint v1, input logic [31:0] za,
                                                 input logic [31:0] z2,
                                                 input logic [31:0] z3);
        triangle_t t;
        longint      v [3];
        logic [63:0] mag [3];
        logic [63:0] w [3];
        logic [63:0] big;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        logic [15:0] nrm [3];
        int k;
        v[0] = v0;
        v[1] = v1;
        v[2] = longint'({32'd0, spacing});
        big = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
            if (mag[i] > big)
                big = mag[i];
        end
        k = 0;
        while ((big >> k) >= (64'd1 << 30))
            k++;
        for (int i = 0; i < 3; i++)
        begin
            w[i] = mag[i] >> k;
            sum = sum + w[i] * w[i];
        end
        len = root_floor(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = 0;
            if (len != 0)
                q = ((w[i] << (FRAC_BITS + 1)) + len) / (2 * len);
            if (v[i] < 0)
                q = -q;
            nrm[i] = q[15:0];
        end
        t.rlo  = row_acc;
        t.rhi  = row_acc + {16'd0, spacing};
        t.clo  = col_acc;
        t.chi  = col_acc + {16'd0, spacing};
        t.kind = kind;
        t.z1   = za;
        t.z2   = z2;
        t.z3   = z3;
        t.nx   = nrm[0];
        t.ny   = nrm[1];
        t.nz   = nrm[2];
        t.last = 1'b0;
        return t;
    endfunction

    // Walks one sample through the grid and queues the triangles it closes.
    function automatic void triangulate(input logic [31:0] zd);
        int unsigned ncols;
        int unsigned col;
        logic [31:0] za;
        logic [31:0] zb;
        logic [31:0] zc;
        longint a;
        longint b;
        longint c;
        longint d;
        triangle_t made [$];
        ncols = grid_cols;
        if (ncols < 2)
            ncols = 2;
        if (ncols > 4096)
            ncols = 4096;
        col = (col_pos >= ncols) ? ncols - 1 : col_pos;
        if (col > 0)
        begin
            za = line_mem[col - 1];
            zb = line_mem[col];
            zc = left_z;
            if (!in_first_row && !nodata(za) && !nodata(zd))
            begin
                a = longint'($signed(za));
                b = longint'($signed(zb));
                c = longint'($signed(zc));
                d = longint'($signed(zd));
                if (!nodata(zc))
                    made.insert(made.size(), build_triangle(1'b0, a - c, c - d, za, zc, zd));
                if (!nodata(zb))
                    made.insert(made.size(), build_triangle(1'b1, b - d, a - b, za, zd, zb));
                if (made.size() > 0)
                    made[made.size() - 1].last = 1'b1;
                foreach (made[i])
                    triangle_queue.insert(triangle_queue.size(), made[i]);
            end
            line_mem[col - 1] = left_z;
            col_acc = col_acc + {16'd0, spacing};
        end
        left_z = zd;
        if (col + 1 >= ncols)
        begin
            line_mem[col] = zd;
            col_pos = 0;
            col_acc = col_origin;
            if (in_first_row)
                in_first_row = 1'b0;
            else
                row_acc = row_acc + {16'd0, spacing};
        end
        else
            col_pos = col + 1;
    endfunction

    function automatic void restart_walk();
        col_pos = 0;
        in_first_row = 1'b1;
        row_acc = row_origin;
        col_acc = col_origin;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sample driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp.valid <= 1'b0;
            smp.elevation <= '0;
            gap_left <= 0;
            nogap_left <= 0;
        end
        else
        begin
            if (smp.valid && smp.ready)
                triangulate(smp.elevation);
            if (!smp.valid || smp.ready)
            begin
                if (gap_left > 0)
                begin
                    smp.valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (sample_queue.size() > 0)
                begin
                    smp.valid <= 1'b1;
                    smp.elevation <= sample_queue.pop_front();
                    if (nogap_left > 0)
                    begin
                        nogap_left <= nogap_left - 1;
                        gap_left <= 0;
                    end
                    else
                    begin
                        if ($urandom_range(0, 99) < 2)
                            nogap_left <= $urandom_range(20, 80);
                        gap_left <= pick_gap();
                    end
                end
                else
                    smp.valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count < 40)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Triangle monitor and receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trif.ready <= 1'b0;
            hold_left <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            if (trif.valid && trif.ready)
            begin
                if (triangle_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count < 40)
                        $display("%0t: unexpected triangle, expected none, actual kind %0d",
                                 $time, trif.triangle_kind);
                end
                else
                begin
                    triangle_t t;
                    t = triangle_queue.pop_front();
                    check_field("row_coord_low", t.rlo, $unsigned(trif.row_coord_low));
                    check_field("row_coord_high", t.rhi, $unsigned(trif.row_coord_high));
                    check_field("col_coord_low", t.clo, $unsigned(trif.col_coord_low));
                    check_field("col_coord_high", t.chi, $unsigned(trif.col_coord_high));
                    check_field("triangle_kind", t.kind, trif.triangle_kind);
                    check_field("z_first", t.z1, $unsigned(trif.z_first));
                    check_field("z_second", t.z2, $unsigned(trif.z_second));
                    check_field("z_third", t.z3, $unsigned(trif.z_third));
                    check_field("normal_x", t.nx, $unsigned(trif.normal_x));
                    check_field("normal_y", t.ny, $unsigned(trif.normal_y));
                    check_field("normal_z", t.nz, $unsigned(trif.normal_z));
                    check_field("last_of_run", t.last, trif.last_of_run);
                end
            end
            if (long_hold_go && !long_hold_done)
            begin
                long_hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                trif.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                trif.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 25)
            begin
                hold_left <= pick_gap();
                trif.ready <= 1'b0;
            end
            else
                trif.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_idle();
        do
            @(posedge clk);
        while (sample_queue.size() != 0 || smp.valid || triangle_queue.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after its last write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [47:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_COLUMNS:    grid_cols = value[12:0];
            REG_ROW_ORIGIN: row_origin = value;
            REG_COL_ORIGIN: col_origin = value;
            REG_SPACING:    spacing = value[31:0];
            REG_NODATA:     marker = value[15:0];
            default:        return;
        endcase
        restart_walk();
    endtask

    task automatic configure(input logic [12:0] cols, input logic [47:0] rorg,
                             input logic [47:0] corg, input logic [31:0] sp,
                             input logic [15:0] nd);
        wait_idle();
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, 48'({$urandom, $urandom}));
        write_reg(REG_NODATA, {32'd0, nd});
        write_reg(REG_SPACING, {16'd0, sp});
        write_reg(REG_ROW_ORIGIN, rorg);
        write_reg(REG_COL_ORIGIN, corg);
        write_reg(REG_COLUMNS, {35'd0, cols});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Builds a sample whose truncated integer part is the current marker.
    function automatic logic [31:0] missing_sample();
        longint m;
        longint f;
        m = longint'($signed(marker));
        f = $urandom_range(0, 65535);
        if (m == -32768)
            f = 0;
        if (m > 0 || (m == 0 && $urandom_range(0, 1)))
            return 32'(m * 65536 + f);
        return 32'(m * 65536 - f);
    endfunction

    function automatic logic [31:0] random_sample(input int nodata_pct, input logic [31:0] base);
        int r;
        r = $urandom_range(0, 99);
        if (r < nodata_pct)
            return missing_sample();
        r = $urandom_range(0, 9);
        if (r < 2)
            return $urandom;
        if (r == 2)
            return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
        return base + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    task automatic push_grid(input int count, input int nodata_pct);
        logic [31:0] base;
        base = $urandom;
        for (int i = 0; i < count; i++)
            add_sample(random_sample(nodata_pct, base));
    endtask

    initial
    begin
        int cols;
        int count;
        int phase;
        logic [47:0] rorg;
        logic [47:0] corg;
        logic [31:0] sp;
        logic [15:0] nd;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        smp.valid = 1'b0;
        smp.elevation = '0;
        trif.ready = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        long_hold_go = 1'b0;
        grid_cols = COLUMNS_RESET;
        row_origin = '0;
        col_origin = '0;
        spacing = SPACING_RESET;
        marker = NODATA_RESET;
        left_z = '0;
        restart_walk();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: two columns, extremes, exact and fractional no-data.
        add_sample(32'h7FFFFFFF);
        add_sample(32'h80000000);
        add_sample(32'h00000000);
        add_sample(32'hFFFFFFFF);
        add_sample(32'(-9999 * 65536));
        add_sample(32'h00010000);
        add_sample(32'(-9999 * 65536 - 32768));
        add_sample(32'h00020000);
        add_sample(32'h00030000);
        add_sample(32'h00030000);
        add_sample(32'(-9998 * 65536 - 1));
        add_sample(32'h7FFFFFFF);

        // Extreme origins wrap, smallest non-zero spacing, largest marker.
        configure(13'd3, 48'h7FFFFFFFFFFF, 48'h800000000000, 32'd1, 16'h7FFF);
        for (int i = 0; i < 9; i++)
            add_sample(i % 4 == 3 ? 32'h7FFF8000 : $urandom);

        // Column count below the range, zero spacing on a flat surface.
        configure(13'd0, 48'hFFFFFFFFFFF0, 48'h000000000010, 32'd0, 16'h0000);
        for (int i = 0; i < 4; i++)
            add_sample(32'h00050000);
        add_sample(32'hFFFF8000);
        add_sample(32'h00050000);

        // Column count above the range, largest spacing, smallest marker.
        configure(13'h1FFF, 48'h0, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 16'h8000);
        push_grid(24, 30);
        configure(13'd4096, 48'h123456789ABC, 48'h0, 32'hFFFFFFFF, 16'h8000);
        push_grid(30, 30);

        phase = 0;
        count = 0;
        while (count < 1000)
        begin
            cols = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(2, 9);
            rorg = ($urandom_range(0, 4) == 0) ? {1'b1, 47'd0} : 48'({$urandom, $urandom});
            corg = ($urandom_range(0, 4) == 0) ? {1'b0, {47{1'b1}}} : 48'({$urandom, $urandom});
            case ($urandom_range(0, 3))
                0:       sp = $urandom;
                1:       sp = 32'hFFFFFFFF;
                default: sp = $urandom_range(1, 1 << 20);
            endcase
            nd = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 20)) - 10);
            configure(13'(cols), rorg, corg, sp, nd);
            if (phase == 3)
                long_hold_go = 1'b1;
            // Mostly whole rows; now and then a broken last row.
            push_grid(cols * $urandom_range(2, 8) + (($urandom_range(0, 3) == 0) ?
                      $urandom_range(1, cols) : 0), $urandom_range(0, 3) == 0 ? 40 : 8);
            count = count + sample_queue.size();
            phase++;
        end

        wait_idle();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
